### rtl/core/assert_macros.svh
// Assertion macros included by the ranked list delta merge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// Plain invariant checked on every clock edge.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

### rtl/core/rldm_pkg.sv
// Package with types and constants of the ranked list delta merge.
package rldm_pkg;
    localparam int unsigned MaxResults = 32;

    typedef enum logic [3:0] {
        t_idle_st,
        t_scan_st,
        t_scan_wait_st,
        t_write_st,
        t_sort_st,
        t_sort_rd_st,
        t_sort_wr_st,
        t_merge_st,
        t_merge_rd_st,
        t_merge_chk_st,
        t_emit_st,
        t_emit_rd_st,
        t_out_st
    } t_state;
endpackage

### rtl/core/ranked_list_delta_merge.sv
// Top level of the ranked list delta merge.
//
// Input words arrive on i_valid/o_ready with page_id, score, last_of_delta,
// event_sec and clock_seconds; o_ready is high only while the block is idle.
// Each word is folded into the delta buffer by a search over the buffer memory
// (a read and a compare per buffered entry), then an overwrite of the match or
// an append, and the write-back. A word with last_of_delta set then starts the
// merge: the buffer is insertion sorted, the sorted entries and the old table
// entries are merged, each old table entry after a check for its membership in
// the buffer, and the scratch table is copied back. The list is then streamed
// out on o_valid/i_ready, one result word per entry up to MaxResults and one
// word per cycle while the receiver is ready. An empty list gives one word with
// entry_valid low. A stalled receiver just holds the result register; no input
// or config word is taken until the last result word is accepted. The config
// channel writes context_id only while the block is idle. Reset clears the
// counts and the state machine; the memories hold stale data that is never
// read before it is written.
`include "assert_macros.svh"
module ranked_list_delta_merge #(
    parameter int unsigned TABLE_DEPTH = 32,
    parameter int unsigned DELTA_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_page_id,
    input  logic signed [31:0]   i_score,
    input  logic                 i_last_of_delta,
    input  logic [47:0]          i_event_sec,
    input  logic [47:0]          i_clock_seconds,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_owner_id,
    output logic [31:0]          o_out_page_id,
    output logic signed [31:0]   o_out_score,
    output logic                 o_entry_valid,
    output logic                 o_last_entry,
    output logic                 o_overflow,
    output logic [47:0]          o_last_update
);
    import rldm_pkg::*;

    localparam int unsigned TW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned TA = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned DW = $clog2(DELTA_DEPTH + 1);
    localparam int unsigned DA = (DELTA_DEPTH > 1) ? $clog2(DELTA_DEPTH) : 1;

    // Memories: the table, a scratch table for the merge result, and the
    // delta buffer (load order) plus a sorted copy of the insertable entries.
    logic [63:0] m_tab [TABLE_DEPTH];
    logic [63:0] m_new [TABLE_DEPTH];
    logic [63:0] m_dlt [DELTA_DEPTH];
    logic [63:0] m_srt [DELTA_DEPTH];

    t_state r_st, n_st;
    logic [TW-1:0] r_tcnt, n_tcnt;
    logic [DW-1:0] r_dcnt, n_dcnt;
    logic r_dovf, n_dovf;
    logic [31:0] r_ctx;
    logic [DW-1:0] r_i, n_i, r_ns, n_ns;
    logic [DW-1:0] r_j, n_j;
    logic [TW-1:0] r_b, n_b, r_nn, n_nn;
    logic [DW-1:0] r_a, n_a;
    logic r_ovf, n_ovf, r_last, n_last, r_found, n_found;
    logic [31:0] r_id;
    logic signed [31:0] r_sc;
    logic [47:0] r_ts;
    logic [63:0] r_hold, n_hold;

    // Memory ports: one write and one registered read each.
    logic dlt_we, tab_we, new_we, srt_we;
    logic [DA-1:0] dlt_wa, dlt_ra, srt_wa, srt_ra;
    logic [TA-1:0] tab_wa, tab_ra, new_wa, new_ra;
    logic [63:0] dlt_wd, tab_wd, new_wd, srt_wd;
    logic [63:0] dlt_q, tab_q, new_q, srt_q;

    always_ff @(posedge i_clk) begin
        if (dlt_we) m_dlt[dlt_wa] <= dlt_wd;
        dlt_q <= m_dlt[dlt_ra];
        if (srt_we) m_srt[srt_wa] <= srt_wd;
        srt_q <= m_srt[srt_ra];
        if (tab_we) m_tab[tab_wa] <= tab_wd;
        tab_q <= m_tab[tab_ra];
        if (new_we) m_new[new_wa] <= new_wd;
        new_q <= m_new[new_ra];
    end

    logic in_acc, out_acc;
    assign o_ready = (r_st == t_idle_st);
    assign o_cfg_ready = (r_st == t_idle_st);
    assign in_acc = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_valid = (r_st == t_out_st);
    assign o_owner_id = r_ctx;
    assign o_last_update = r_ts;
    assign o_overflow = r_ovf;

    logic [31:0] r_pid;
    logic signed [31:0] r_psc;
    logic r_pval, r_plast;
    assign o_out_page_id = r_pid;
    assign o_out_score = r_psc;
    assign o_entry_valid = r_pval;
    assign o_last_entry = r_plast;

    logic [TW-1:0] emit_n;
    assign emit_n = (32'(r_nn) > MaxResults) ? TW'(MaxResults) : r_nn;

    logic signed [31:0] dsc, tsc, hsc;
    assign dsc = dlt_q[31:0];
    assign tsc = tab_q[31:0];
    assign hsc = r_hold[31:0];

    logic take_d;
    logic [63:0] pick;

    always_comb begin
        n_st = r_st; n_tcnt = r_tcnt; n_dcnt = r_dcnt; n_dovf = r_dovf;
        n_i = r_i; n_ns = r_ns; n_j = r_j; n_b = r_b; n_nn = r_nn; n_a = r_a;
        n_ovf = r_ovf; n_last = r_last; n_found = r_found; n_hold = r_hold;
        dlt_we = 1'b0; dlt_wa = r_dcnt[DA-1:0]; dlt_wd = {r_id, r_sc};
        dlt_ra = r_i[DA-1:0];
        srt_we = 1'b0; srt_wa = r_j[DA-1:0]; srt_wd = r_hold;
        srt_ra = r_j[DA-1:0];
        tab_we = 1'b0; tab_wa = r_b[TA-1:0]; tab_wd = new_q;
        tab_ra = r_b[TA-1:0];
        new_we = 1'b0; new_wa = r_nn[TA-1:0]; new_wd = r_hold;
        new_ra = r_b[TA-1:0];
        take_d = 1'b0; pick = r_hold;
        unique case (r_st)
            t_idle_st: begin
                if (in_acc) begin
                    n_i = '0; n_found = 1'b0; n_last = i_last_of_delta;
                    n_st = t_scan_st;
                end
            end
            // Search the buffer for the id: read entry r_i, compare next cycle.
            t_scan_st: begin
                if (r_i == r_dcnt) begin
                    if (r_dcnt < DW'(DELTA_DEPTH)) begin
                        dlt_we = 1'b1; n_dcnt = r_dcnt + 1'b1;
                    end else begin
                        n_dovf = 1'b1;
                    end
                    n_st = t_write_st;
                end else begin
                    n_st = t_scan_wait_st;
                end
            end
            t_scan_wait_st: begin
                if (dlt_q[63:32] == r_id) begin
                    dlt_we = 1'b1; dlt_wa = r_i[DA-1:0];
                    n_st = t_write_st;
                end else begin
                    n_i = r_i + 1'b1; n_st = t_scan_st;
                end
            end
            t_write_st: begin
                if (r_last) begin
                    n_i = '0; n_ns = '0; n_st = t_sort_st;
                end else begin
                    n_st = t_idle_st;
                end
            end
            // Insertion sort: fetch buffer entry r_i into r_hold.
            t_sort_st: begin
                if (r_i == r_dcnt) begin
                    n_a = '0; n_b = '0; n_nn = '0; n_ovf = r_dovf;
                    n_st = t_merge_st;
                end else begin
                    n_st = t_sort_rd_st;
                end
            end
            t_sort_rd_st: begin
                n_hold = dlt_q;
                n_i = r_i + 1'b1;
                if (dlt_q[63:32] == '0 || dsc < 0) begin
                    n_st = t_sort_st;
                end else begin
                    n_j = r_ns; n_st = t_sort_wr_st;
                    srt_ra = DA'(r_ns - 1'b1);
                end
            end
            // srt_q holds entry j-1; shift it up or drop the held one at j.
            t_sort_wr_st: begin
                if (r_j != '0 && $signed(srt_q[31:0]) < hsc) begin
                    srt_we = 1'b1; srt_wa = r_j[DA-1:0]; srt_wd = srt_q;
                    n_j = r_j - 1'b1;
                    srt_ra = DA'(r_j - 2'd2);
                end else begin
                    srt_we = 1'b1;
                    n_ns = r_ns + 1'b1; n_st = t_sort_st;
                end
            end
            // Merge: read sorted entry a and table entry b.
            t_merge_st: begin
                if (r_a == r_ns && r_b == r_tcnt) begin
                    n_b = '0; n_st = t_emit_st;
                end else begin
                    srt_ra = r_a[DA-1:0];
                    n_st = t_merge_rd_st;
                end
            end
            t_merge_rd_st: begin
                take_d = (r_a < r_ns) &&
                         (r_b >= r_tcnt || $signed(srt_q[31:0]) >= tsc);
                pick = take_d ? srt_q : tab_q;
                n_hold = pick;
                if (take_d) begin
                    n_a = r_a + 1'b1;
                    if (r_nn < TW'(TABLE_DEPTH)) begin
                        new_we = 1'b1; new_wd = pick; n_nn = r_nn + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_st = t_merge_st;
                end else begin
                    n_b = r_b + 1'b1;
                    n_i = '0; n_st = t_merge_chk_st;
                end
            end
            // Membership of the old id in the buffer, entry by entry: read, then compare.
            t_merge_chk_st: begin
                if (r_i == r_dcnt) begin
                    if (r_nn < TW'(TABLE_DEPTH)) begin
                        new_we = 1'b1; n_nn = r_nn + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_st = t_merge_st;
                end else if (r_found) begin
                    if (dlt_q[63:32] == r_hold[63:32]) begin
                        n_st = t_merge_st;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                    n_found = 1'b0;
                end else begin
                    n_found = 1'b1;
                end
                tab_ra = r_b[TA-1:0];
            end
            // Copy scratch to table, then fetch the first result.
            t_emit_st: begin
                n_found = 1'b0;
                if (r_b == r_nn) begin
                    n_tcnt = r_nn; n_dcnt = '0; n_dovf = 1'b0;
                    n_b = '0; n_st = t_emit_rd_st;
                    // Fetch the first entry for the result register.
                    tab_ra = '0;
                end else begin
                    n_st = t_emit_rd_st;
                end
            end
            t_emit_rd_st: begin
                if (r_tcnt == r_nn && r_dcnt == '0 && r_found) begin
                    n_st = t_out_st;
                end else if (r_tcnt == r_nn && r_dcnt == '0 && r_b == '0
                             && !r_found) begin
                    n_found = 1'b1; n_st = t_out_st;
                    // Prefetch the second entry for the first accepted word.
                    tab_ra = TA'(1);
                end else begin
                    tab_we = 1'b1; n_b = r_b + 1'b1; n_st = t_emit_st;
                end
            end
            t_out_st: begin
                if (out_acc) begin
                    if (r_plast) begin
                        n_st = t_idle_st;
                    end else begin
                        n_b = r_b + 1'b1; n_st = t_out_st;
                    end
                end
                // Keep the entry after the one on display in tab_q.
                tab_ra = out_acc ? TA'(r_b + 2'd2) : TA'(r_b + 1'b1);
            end
            default: n_st = t_idle_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_idle_st;
            r_tcnt <= '0;
            r_dcnt <= '0;
            r_dovf <= 1'b0;
            r_ctx <= '0;
        end else begin
            r_st <= n_st;
            r_tcnt <= n_tcnt;
            r_dcnt <= n_dcnt;
            r_dovf <= n_dovf;
            if (i_cfg_valid && o_cfg_ready) r_ctx <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_ns <= n_ns; r_j <= n_j; r_b <= n_b; r_nn <= n_nn;
        r_a <= n_a; r_ovf <= n_ovf; r_last <= n_last; r_found <= n_found;
        r_hold <= n_hold;
        if (in_acc) begin
            r_id <= i_page_id;
            r_sc <= i_score;
            r_ts <= (i_event_sec != '0) ? i_event_sec : i_clock_seconds;
        end
        // Result register: loaded when entering the output state or after
        // a word is taken; tab_q then holds the next entry to show.
        if ((r_st != t_out_st && n_st == t_out_st) || (out_acc && !r_plast)) begin
            if (r_nn == '0) begin
                r_pid <= '0; r_psc <= '0; r_pval <= 1'b0; r_plast <= 1'b1;
            end else begin
                r_pid <= tab_q[63:32]; r_psc <= tab_q[31:0]; r_pval <= 1'b1;
                r_plast <= ((r_st == t_out_st ? r_b + 1'b1 : r_b) + 1'b1)
                           == emit_n;
            end
        end
    end

    `ASSERT_IMPL(a_out_only_in_out, i_clk, i_rst_n,
                 !(o_valid && o_ready), "result and input both open")
    `ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n,
                 (r_tcnt <= TW'(TABLE_DEPTH)) && (r_dcnt <= DW'(DELTA_DEPTH)),
                 "count beyond depth")
    `ASSERT_IMPL(a_empty_last, i_clk, i_rst_n,
                 !(o_valid && !o_entry_valid && !o_last_entry),
                 "empty result not marked last")
endmodule
